// File: src/azcs_pkg.sv
`default_nettype none
package azcs_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned CfgW     = 8;
  localparam int unsigned CountW   = 9;
  localparam int unsigned SumW     = 24;
  localparam int unsigned DivW     = SumW + 2;
  localparam int unsigned DvsW     = CfgW + 1;
  localparam int unsigned DivCntW  = $clog2(DivW);
  localparam int unsigned RadW     = 2 * SampleW;
  localparam int unsigned RootW    = SampleW;
  localparam int unsigned RemW     = RootW + 2;
  localparam int unsigned SqCntW   = $clog2(RootW);
  localparam int unsigned AddrW    = 3;

  localparam logic [AddrW-1:0] AddrWarmup = 3'd0;
  localparam logic [AddrW-1:0] AddrCalib  = 3'd4;

  localparam logic [CfgW-1:0] WarmupReset = 8'd40;
  localparam logic [CfgW-1:0] CalibReset  = 8'd40;

  typedef enum logic [1:0] {
    PhDisc  = 2'd0,
    PhWarm  = 2'd1,
    PhCalib = 2'd2,
    PhMeas  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SQST,
    S_SQRT,
    S_OUT
  } state_e;

endpackage
`default_nettype wire

// File: src/azcs_if.sv
`default_nettype none
interface azcs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_pressure;
  logic        reading_ok;

  modport source (output valid, output raw_pressure, output reading_ok, input ready);
  modport sink (input valid, input raw_pressure, input reading_ok, output ready);
endinterface

interface azcs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  phase;
  logic        connected;
  logic [15:0] airspeed_q8_8;
  logic [15:0] zero_level;

  modport source (output valid, output phase, output connected, output airspeed_q8_8,
                  output zero_level, input ready);
  modport sink (input valid, input phase, input connected, input airspeed_q8_8,
                input zero_level, output ready);
endinterface
`default_nettype wire

// File: src/azcs_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module azcs_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [azcs_pkg::DivW-1:0]  dividend_i,
  input  wire logic [azcs_pkg::DvsW-1:0]  divisor_i,
  output logic                            done_o,
  output logic [azcs_pkg::DivW-1:0]       quotient_o
);

  logic                            active_q, active_d;
  logic                            done_q, done_d;
  logic [azcs_pkg::DivCntW-1:0]    cnt_q, cnt_d;
  logic [azcs_pkg::DivW-1:0]       acc_q, acc_d;
  logic [azcs_pkg::DvsW-1:0]       rem_q, rem_d;
  logic [azcs_pkg::DvsW-1:0]       dvs_q, dvs_d;
  logic [azcs_pkg::DvsW:0]         rem_sh;
  logic                            ge;

  always_comb begin
    rem_sh   = {rem_q, acc_q[azcs_pkg::DivW-1]};
    ge       = rem_sh >= {1'b0, dvs_q};
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      acc_d    = dividend_i;
      rem_d    = '0;
      dvs_d    = divisor_i;
    end else if (active_q) begin
      rem_d = ge ? azcs_pkg::DvsW'(rem_sh - {1'b0, dvs_q}) : azcs_pkg::DvsW'(rem_sh);
      acc_d = {acc_q[azcs_pkg::DivW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == azcs_pkg::DivCntW'(azcs_pkg::DivW - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q;

endmodule
`default_nettype wire

// File: src/azcs_sqrt.sv
`default_nettype none
// digit-by-digit square root, two radicand bits per cycle
module azcs_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [azcs_pkg::RadW-1:0]  radicand_i,
  output logic                            done_o,
  output logic [azcs_pkg::RootW-1:0]      root_o
);

  logic                            active_q, active_d;
  logic                            done_q, done_d;
  logic [azcs_pkg::SqCntW-1:0]     cnt_q, cnt_d;
  logic [azcs_pkg::RadW-1:0]       rad_q, rad_d;
  logic [azcs_pkg::RootW-1:0]      root_q, root_d;
  logic [azcs_pkg::RemW-1:0]       rem_q, rem_d;
  logic [azcs_pkg::RemW+1:0]       rem_sh;
  logic [azcs_pkg::RemW+1:0]       trial;
  logic                            ge;

  always_comb begin
    rem_sh   = {rem_q, rad_q[azcs_pkg::RadW-1 -: 2]};
    trial    = {2'b00, root_q, 2'b01};
    ge       = rem_sh >= trial;
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    rad_d    = rad_q;
    root_d   = root_q;
    rem_d    = rem_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      rad_d    = radicand_i;
      root_d   = '0;
      rem_d    = '0;
    end else if (active_q) begin
      rem_d  = ge ? azcs_pkg::RemW'(rem_sh - trial) : azcs_pkg::RemW'(rem_sh);
      root_d = {root_q[azcs_pkg::RootW-2:0], ge};
      rad_d  = {rad_q[azcs_pkg::RadW-3:0], 2'b00};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == azcs_pkg::SqCntW'(azcs_pkg::RootW - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

// File: src/airspeed_zero_cal_sqrt_top.sv
// Path from input transaction to result valid: disconnected, warm-up and calibration samples
// go straight to the result register, a measured sample passes through the square root, and
// the sample that completes calibration passes through the divider, then the square root.
// One transaction in flight: the next is accepted only after the last result is loaded into
// the result register, which may wait on out_o.ready.
// rst_ni async active low: registers back to 40/40, counter, sum and zero point cleared.
`default_nettype none
module airspeed_zero_cal_sqrt_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  azcs_in_if.sink                          in_i,
  azcs_out_if.source                       out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [azcs_pkg::AddrW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  azcs_pkg::state_e                    state_q, state_d;
  logic [azcs_pkg::CfgW-1:0]           warmup_q, calib_q;
  logic [azcs_pkg::CountW-1:0]         cnt_q, cnt_d;
  logic [azcs_pkg::SumW-1:0]           sum_q, sum_d;
  logic [azcs_pkg::SampleW-1:0]        zero_q, zero_d;
  logic [azcs_pkg::SampleW-1:0]        sample_q, sample_d;
  azcs_pkg::phase_e                    phase_q, phase_d;
  logic                                ok_q, ok_d;
  logic [azcs_pkg::RootW-1:0]          speed_q, speed_d;
  logic                                ov_q, ov_d;
  azcs_pkg::phase_e                    ophase_q, ophase_d;
  logic                                ook_q, ook_d;
  logic [azcs_pkg::RootW-1:0]          ospeed_q, ospeed_d;
  logic [azcs_pkg::SampleW-1:0]        ozero_q, ozero_d;

  logic                                accept, load, cfg_wr;
  logic [azcs_pkg::CountW-1:0]         end_cnt, cnt_inc;
  logic [azcs_pkg::SumW-1:0]           sum_new;
  logic                                div_start, div_done, sq_start, sq_done;
  logic [azcs_pkg::DivW-1:0]           dividend, quotient;
  logic [azcs_pkg::DvsW-1:0]           divisor;
  logic [azcs_pkg::SampleW-1:0]        diff;
  logic [azcs_pkg::RadW-1:0]           radicand;
  logic [azcs_pkg::RootW-1:0]          root;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr)
      azcs_pkg::AddrWarmup: prdata = {24'd0, warmup_q};
      azcs_pkg::AddrCalib:  prdata = {24'd0, calib_q};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warmup_q <= azcs_pkg::WarmupReset;
      calib_q  <= azcs_pkg::CalibReset;
    end else if (cfg_wr) begin
      if (paddr == azcs_pkg::AddrWarmup) begin
        warmup_q <= pwdata[azcs_pkg::CfgW-1:0];
      end
      if (paddr == azcs_pkg::AddrCalib) begin
        calib_q <= pwdata[azcs_pkg::CfgW-1:0];
      end
    end
  end

  assign in_i.ready = (state_q == azcs_pkg::S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign end_cnt    = {1'b0, warmup_q} + {1'b0, calib_q};
  assign cnt_inc    = cnt_q + 1'b1;
  assign sum_new    = sum_q + azcs_pkg::SumW'(in_i.raw_pressure);
  assign dividend   = {1'b0, sum_new, 1'b0} + azcs_pkg::DivW'(calib_q);
  assign divisor    = {calib_q, 1'b0};
  assign diff       = (sample_q >= zero_q) ? sample_q - zero_q : zero_q - sample_q;
  assign radicand   = {diff, {azcs_pkg::SampleW{1'b0}}};
  assign sq_start   = (state_q == azcs_pkg::S_SQST);
  assign load       = (state_q == azcs_pkg::S_OUT) && (!ov_q || out_o.ready);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    zero_d    = zero_q;
    sample_d  = sample_q;
    phase_d   = phase_q;
    ok_d      = ok_q;
    speed_d   = speed_q;
    div_start = 1'b0;
    unique case (state_q)
      azcs_pkg::S_IDLE: begin
        if (accept) begin
          sample_d = in_i.raw_pressure;
          ok_d     = in_i.reading_ok;
          speed_d  = '0;
          state_d  = azcs_pkg::S_OUT;
          if (!in_i.reading_ok) begin
            phase_d = azcs_pkg::PhDisc;
          end else if (cnt_q < {1'b0, warmup_q}) begin
            cnt_d   = cnt_inc;
            phase_d = azcs_pkg::PhWarm;
          end else if (cnt_q < end_cnt) begin
            cnt_d = cnt_inc;
            sum_d = sum_new;
            if (cnt_inc == end_cnt) begin
              div_start = 1'b1;
              phase_d   = azcs_pkg::PhMeas;
              state_d   = azcs_pkg::S_DIV;
            end else begin
              phase_d = azcs_pkg::PhCalib;
            end
          end else begin
            phase_d = azcs_pkg::PhMeas;
            state_d = azcs_pkg::S_SQST;
          end
        end
      end
      azcs_pkg::S_DIV: begin
        if (div_done) begin
          zero_d  = (quotient[azcs_pkg::DivW-1:azcs_pkg::SampleW] != '0)
                    ? {azcs_pkg::SampleW{1'b1}} : quotient[azcs_pkg::SampleW-1:0];
          state_d = azcs_pkg::S_SQST;
        end
      end
      azcs_pkg::S_SQST: begin
        state_d = azcs_pkg::S_SQRT;
      end
      azcs_pkg::S_SQRT: begin
        if (sq_done) begin
          speed_d = root;
          state_d = azcs_pkg::S_OUT;
        end
      end
      azcs_pkg::S_OUT: begin
        if (load) begin
          state_d = azcs_pkg::S_IDLE;
        end
      end
      default: state_d = azcs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ov_d     = ov_q;
    ophase_d = ophase_q;
    ook_d    = ook_q;
    ospeed_d = ospeed_q;
    ozero_d  = ozero_q;
    if (out_o.valid && out_o.ready) begin
      ov_d = 1'b0;
    end
    if (load) begin
      ov_d     = 1'b1;
      ophase_d = phase_q;
      ook_d    = ok_q;
      ospeed_d = speed_q;
      ozero_d  = zero_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= azcs_pkg::S_IDLE;
      cnt_q   <= '0;
      sum_q   <= '0;
      zero_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      zero_q  <= zero_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    phase_q  <= phase_d;
    ok_q     <= ok_d;
    speed_q  <= speed_d;
    ophase_q <= ophase_d;
    ook_q    <= ook_d;
    ospeed_q <= ospeed_d;
    ozero_q  <= ozero_d;
  end

  azcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  azcs_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (radicand),
    .done_o     (sq_done),
    .root_o     (root)
  );

  assign out_o.valid         = ov_q;
  assign out_o.phase         = ophase_q;
  assign out_o.connected     = ook_q;
  assign out_o.airspeed_q8_8 = ospeed_q;
  assign out_o.zero_level    = ozero_q;

`ifndef ASSERT_OFF
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == azcs_pkg::S_DIV)
    else $error("divider finished outside divide state");

  a_sq_done_in_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == azcs_pkg::S_SQRT)
    else $error("square root finished outside root state");

  a_speed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ophase_q != azcs_pkg::PhMeas) |-> ospeed_q == '0)
    else $error("nonzero airspeed outside measuring");

  a_disc_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !ook_q) |-> ophase_q == azcs_pkg::PhDisc)
    else $error("invalid reading not reported disconnected");

  a_cnt_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_i.reading_ok) |=> $stable(cnt_q) && $stable(sum_q))
    else $error("invalid reading changed state");
`endif

endmodule
`default_nettype wire
